### design/acf_pkg.sv
// Shared types and constants for the atom clash filter.
`timescale 1ns / 1ps

package acf_pkg;

    localparam int RADIUS_W = 14;
    localparam int RSQ_W    = 2 * RADIUS_W;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 14'd320;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } acf_state_t;

    typedef struct packed {
        logic clear;
        logic load;
    } acf_store_cmd_t;

    typedef struct packed {
        logic full;
        logic in_box;
    } acf_store_stat_t;

endpackage

### design/acf_store.sv
// Atom coordinate memory, atom count and bounding box tracking.
`timescale 1ns / 1ps

module acf_store import acf_pkg::*; #(
    parameter int MAX_ATOMS  = 4096,
    parameter int COORD_BITS = 18,
    parameter int CNT_W      = 13,
    parameter int ADDR_W     = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  acf_store_cmd_t               cmd,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    input  logic signed [COORD_BITS-1:0] pt_z,
    input  logic                         rd_en,
    input  logic        [ADDR_W-1:0]     rd_addr,
    output logic signed [COORD_BITS-1:0] rd_x,
    output logic signed [COORD_BITS-1:0] rd_y,
    output logic signed [COORD_BITS-1:0] rd_z,
    output logic        [CNT_W-1:0]      count,
    output acf_store_stat_t              stat
);

    localparam int WORD_W = 3 * COORD_BITS;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [WORD_W-1:0] mem [MAX_ATOMS];
    logic [WORD_W-1:0] rd_data_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic signed [COORD_BITS-1:0] x_low_reg, x_low_next, x_high_reg, x_high_next;
    logic signed [COORD_BITS-1:0] y_low_reg, y_low_next, y_high_reg, y_high_next;
    logic signed [COORD_BITS-1:0] z_low_reg, z_low_next, z_high_reg, z_high_next;

    logic full;
    logic do_load;

    assign full    = (count_reg == CNT_W'(MAX_ATOMS));
    assign do_load = cmd.load && !full;

    always_ff @(posedge aclk) begin
        if (do_load) begin
            mem[count_reg[ADDR_W-1:0]] <= {pt_x, pt_y, pt_z};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_x = rd_data_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign rd_y = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign rd_z = rd_data_reg[COORD_BITS-1:0];

    always_comb begin
        count_next  = count_reg;
        x_low_next  = x_low_reg;
        x_high_next = x_high_reg;
        y_low_next  = y_low_reg;
        y_high_next = y_high_reg;
        z_low_next  = z_low_reg;
        z_high_next = z_high_reg;
        if (cmd.clear) begin
            count_next  = '0;
            x_low_next  = COORD_MAX;
            x_high_next = COORD_MIN;
            y_low_next  = COORD_MAX;
            y_high_next = COORD_MIN;
            z_low_next  = COORD_MAX;
            z_high_next = COORD_MIN;
        end else if (do_load) begin
            count_next = count_reg + CNT_W'(1);
            if (pt_x < x_low_reg)  x_low_next  = pt_x;
            if (pt_x > x_high_reg) x_high_next = pt_x;
            if (pt_y < y_low_reg)  y_low_next  = pt_y;
            if (pt_y > y_high_reg) y_high_next = pt_y;
            if (pt_z < z_low_reg)  z_low_next  = pt_z;
            if (pt_z > z_high_reg) z_high_next = pt_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            x_low_reg  <= COORD_MAX;
            x_high_reg <= COORD_MIN;
            y_low_reg  <= COORD_MAX;
            y_high_reg <= COORD_MIN;
            z_low_reg  <= COORD_MAX;
            z_high_reg <= COORD_MIN;
        end else begin
            count_reg  <= count_next;
            x_low_reg  <= x_low_next;
            x_high_reg <= x_high_next;
            y_low_reg  <= y_low_next;
            y_high_reg <= y_high_next;
            z_low_reg  <= z_low_next;
            z_high_reg <= z_high_next;
        end
    end

    assign count       = count_reg;
    assign stat.full   = full;
    assign stat.in_box = (pt_x > x_low_reg) && (pt_x < x_high_reg) &&
                         (pt_y > y_low_reg) && (pt_y < y_high_reg) &&
                         (pt_z > z_low_reg) && (pt_z < z_high_reg);

endmodule

### design/acf_scan.sv
// Pipelined squared-distance test of one stored atom per cycle against the query point.
`timescale 1ns / 1ps

module acf_scan import acf_pkg::*; #(
    parameter int COORD_BITS = 18
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic signed [COORD_BITS-1:0] atom_x,
    input  logic signed [COORD_BITS-1:0] atom_y,
    input  logic signed [COORD_BITS-1:0] atom_z,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    input  logic signed [COORD_BITS-1:0] q_z,
    input  logic        [RSQ_W-1:0]      rsq,
    output logic                         hit,
    output logic                         busy
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? -d : d;
        return m[COORD_BITS-1:0];
    endfunction

    logic v1_reg, v2_reg, v3_reg, hit_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]       sx_reg, sy_reg, sz_reg;
    logic [SUM_W-1:0]      sum;

    assign sum = SUM_W'(sx_reg) + SUM_W'(sy_reg) + SUM_W'(sz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            v1_reg  <= rd_en;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            hit_reg <= v3_reg && (CMP_W'(sum) <= CMP_W'(rsq));
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg <= abs_diff(atom_x, q_x);
        dy_reg <= abs_diff(atom_y, q_y);
        dz_reg <= abs_diff(atom_z, q_z);
        sx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        sz_reg <= SQ_W'(dz_reg) * SQ_W'(dz_reg);
    end

    assign hit  = hit_reg;
    assign busy = v1_reg || v2_reg || v3_reg;

endmodule

### design/atom_clash_filter.sv
// Top level of the atom clash filter: control, configuration and result register.
`timescale 1ns / 1ps

// Each input word is a clear, an atom load or a query point; every word gives one
// result word. Atoms go into a store of MAX_ATOMS entries with one write and one read
// port; a load into a full store is dropped with m_status set. A query outside the
// strict bounding box of the loaded atoms (or on an empty store) is kept at once.
// A query inside the box reads the store one atom per cycle into a four-stage
// squared-distance pipeline and stops reading once a clash comes out of it; up to
// three more reads are then in flight and drain before the result word is formed.
// The scan is bounded by the one store read port. One word is worked at a time; a
// finished result may wait in the output register while the next word is taken.
// A write on the cfg channel sets the clash radius (reset 320, 5.0 Angstrom).

module atom_clash_filter import acf_pkg::*; #(
    parameter int MAX_ATOMS  = 4096,
    parameter int COORD_BITS = 18
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [RADIUS_W-1:0]   cfg_clash_radius,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic        [1:0]            s_action,
    input  logic signed [COORD_BITS-1:0] s_coord_x,
    input  logic signed [COORD_BITS-1:0] s_coord_y,
    input  logic signed [COORD_BITS-1:0] s_coord_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kept,
    output logic                         m_in_box,
    output logic                         m_status
);

    localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
    localparam int ADDR_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam logic [RSQ_W-1:0] RSQ_RESET = RSQ_W'(RADIUS_RESET) * RSQ_W'(RADIUS_RESET);

    acf_state_t state_reg, state_next;

    logic [RSQ_W-1:0] rsq_reg;
    logic signed [COORD_BITS-1:0] q_x_reg, q_y_reg, q_z_reg;
    logic [CNT_W-1:0] addr_reg;
    logic hit_seen_reg;
    logic res_kept_reg, res_in_box_reg, res_status_reg;
    logic m_valid_reg, m_kept_reg, m_in_box_reg, m_status_reg;

    acf_store_cmd_t  cmd;
    acf_store_stat_t stat;
    logic [CNT_W-1:0] count;
    logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z;

    logic s_accept, issue, emit, out_free;
    logic scan_hit, scan_busy, hit_any, issued_all, scan_done;
    logic acc_kept, acc_status, acc_scan;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsq_reg <= RSQ_RESET;
        end else if (cfg_valid) begin
            rsq_reg <= RSQ_W'(cfg_clash_radius) * RSQ_W'(cfg_clash_radius);
        end
    end

    acf_store #(
        .MAX_ATOMS  (MAX_ATOMS),
        .COORD_BITS (COORD_BITS),
        .CNT_W      (CNT_W),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .pt_x    (s_coord_x),
        .pt_y    (s_coord_y),
        .pt_z    (s_coord_z),
        .rd_en   (issue),
        .rd_addr (addr_reg[ADDR_W-1:0]),
        .rd_x    (rd_x),
        .rd_y    (rd_y),
        .rd_z    (rd_z),
        .count   (count),
        .stat    (stat)
    );

    acf_scan #(
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (issue),
        .atom_x  (rd_x),
        .atom_y  (rd_y),
        .atom_z  (rd_z),
        .q_x     (q_x_reg),
        .q_y     (q_y_reg),
        .q_z     (q_z_reg),
        .rsq     (rsq_reg),
        .hit     (scan_hit),
        .busy    (scan_busy)
    );

    assign s_accept   = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign hit_any    = hit_seen_reg || scan_hit;
    assign issued_all = (addr_reg == count);
    assign scan_done  = (issued_all || hit_any) && !scan_busy;

    // decode of the accepted word
    always_comb begin
        acc_kept   = 1'b0;
        acc_status = 1'b0;
        acc_scan   = 1'b0;
        cmd.clear  = 1'b0;
        cmd.load   = 1'b0;
        unique case (s_action)
            ACT_CLEAR: begin
                cmd.clear = s_accept;
            end
            ACT_LOAD: begin
                cmd.load   = s_accept;
                acc_status = stat.full;
            end
            ACT_QUERY: begin
                acc_scan = stat.in_box;
                acc_kept = !stat.in_box;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = acc_scan ? ST_SCAN : ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        issue   = 1'b0;
        emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: issue   = !issued_all && !hit_any;
            ST_EMIT: emit    = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            hit_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                addr_reg     <= '0;
                hit_seen_reg <= 1'b0;
            end else begin
                if (issue) begin
                    addr_reg <= addr_reg + CNT_W'(1);
                end
                if (scan_hit) begin
                    hit_seen_reg <= 1'b1;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            q_x_reg        <= s_coord_x;
            q_y_reg        <= s_coord_y;
            q_z_reg        <= s_coord_z;
            res_kept_reg   <= acc_kept;
            res_in_box_reg <= 1'b0;
            res_status_reg <= acc_status;
        end else if (state_reg == ST_SCAN && scan_done) begin
            res_kept_reg   <= !hit_any;
            res_in_box_reg <= 1'b1;
        end
        if (emit) begin
            m_kept_reg   <= res_kept_reg;
            m_in_box_reg <= res_in_box_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_kept   = m_kept_reg;
    assign m_in_box = m_in_box_reg;
    assign m_status = m_status_reg;

endmodule

### design/acf_checker.sv
// Port-level checks for the atom clash filter and their binding to the top level.
`timescale 1ns / 1ps

module acf_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_kept,
    input logic m_in_box,
    input logic m_status
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kept) && $stable(m_in_box)
                                && $stable(m_status))
        else $error("result word changed while stalled");

    // full-store flag only comes with a load, kept only with a query
    a_status_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_status && m_kept))
        else $error("status and kept both set");

    a_status_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_status && m_in_box))
        else $error("status and in_box both set");

    // one word in work at a time
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in work");

endmodule

bind atom_clash_filter acf_checker u_acf_checker (.*);

### tb/sv/tb_atom_clash_filter.sv
`timescale 1ns / 1ps
// Self-checking testbench for atom_clash_filter: directed and random words, random stalls.

module tb_atom_clash_filter;
    import acf_pkg::*;

    localparam int CW         = 18;
    localparam int NATOMS     = 4096;
    localparam int CMAX       = (1 << (CW - 1)) - 1;
    localparam int CMIN       = -(1 << (CW - 1));
    localparam int LONG_HOLD  = 300;
    localparam int RAND_WORDS = 95;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef logic signed [CW-1:0] coord_t;
    typedef struct {
        logic [1:0] act;
        coord_t     x;
        coord_t     y;
        coord_t     z;
    } word_t;
    typedef struct packed {
        logic kept;
        logic in_box;
        logic status;
    } verdict_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [RADIUS_W-1:0] cfg_clash_radius = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_action = ACT_CLEAR;
    coord_t              s_coord_x = '0, s_coord_y = '0, s_coord_z = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_kept, m_in_box, m_status;

    // shadow of the filter state
    coord_t              atom_x [NATOMS];
    coord_t              atom_y [NATOMS];
    coord_t              atom_z [NATOMS];
    int                  atom_cnt;
    int                  box_lo [3];
    int                  box_hi [3];
    logic [RADIUS_W-1:0] radius_now;

    word_t    pending_q [$];
    verdict_t verdict_q [$];

    int errors = 0;
    bit quiet = 1'b0;
    int hold_reqs = 0, holds_done = 0;
    int drv_gap = 0, rcv_wait = 0;
    int n_pushed = 0, n_accepted = 0, n_offered = 0;
    int n_inbox = 0, n_clash = 0, n_dropped = 0, n_settings = 0;

    atom_clash_filter u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_clash_radius (cfg_clash_radius),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_coord_x        (s_coord_x),
        .s_coord_y        (s_coord_y),
        .s_coord_z        (s_coord_z),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kept           (m_kept),
        .m_in_box         (m_in_box),
        .m_status         (m_status)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic void clear_box();
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = CMAX;
            box_hi[a] = CMIN;
        end
    endfunction

    function automatic verdict_t predict_filter(word_t w);
        verdict_t v;
        int       p [3];
        longint   rsq, d0, d1, d2;
        logic     boxed;
        v = '0;
        p[0] = w.x;
        p[1] = w.y;
        p[2] = w.z;
        case (w.act)
            ACT_CLEAR: begin
                atom_cnt = 0;
                clear_box();
            end
            ACT_LOAD: begin
                if (atom_cnt >= NATOMS) begin
                    v.status = 1'b1;
                end else begin
                    atom_x[atom_cnt] = w.x;
                    atom_y[atom_cnt] = w.y;
                    atom_z[atom_cnt] = w.z;
                    atom_cnt++;
                    for (int a = 0; a < 3; a++) begin
                        if (p[a] < box_lo[a]) box_lo[a] = p[a];
                        if (p[a] > box_hi[a]) box_hi[a] = p[a];
                    end
                end
            end
            ACT_QUERY: begin
                boxed = (atom_cnt != 0);
                for (int a = 0; a < 3; a++) begin
                    if (!(p[a] > box_lo[a] && p[a] < box_hi[a])) boxed = 1'b0;
                end
                v.kept = 1'b1;
                v.in_box = boxed;
                if (boxed) begin
                    rsq = longint'(radius_now) * longint'(radius_now);
                    for (int i = 0; i < atom_cnt; i++) begin
                        d0 = longint'(atom_x[i]) - p[0];
                        d1 = longint'(atom_y[i]) - p[1];
                        d2 = longint'(atom_z[i]) - p[2];
                        if (d0 * d0 + d1 * d1 + d2 * d2 <= rsq) begin
                            v.kept = 1'b0;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic void check_bit(string field, logic want, logic got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0b, got %0b", $time, field, want, got);
        end
    endfunction

    function automatic coord_t fit(longint v);
        if (v > CMAX) return coord_t'(CMAX);
        if (v < CMIN) return coord_t'(CMIN);
        return coord_t'(v);
    endfunction

    function automatic int jitter(int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic int any_coord();
        return int'(coord_t'($urandom));
    endfunction

    // input driver
    always @(posedge aclk) begin : drive_words
        word_t    w;
        verdict_t v;
        if (!aresetn) begin
            s_valid <= 1'b0;
            drv_gap <= 0;
            atom_cnt = 0;
            clear_box();
            radius_now = RADIUS_RESET;
        end else begin
            if (s_valid && s_ready) begin
                w.act = s_action;
                w.x = s_coord_x;
                w.y = s_coord_y;
                w.z = s_coord_z;
                v = predict_filter(w);
                verdict_q.push_back(v);
                n_accepted++;
                if (v.in_box) n_inbox++;
                if (v.in_box && !v.kept) n_clash++;
                if (v.status) n_dropped++;
            end
            if (!s_valid || s_ready) begin
                if (drv_gap > 0) begin
                    s_valid <= 1'b0;
                    drv_gap <= drv_gap - 1;
                end else if (pending_q.size() != 0) begin
                    w = pending_q.pop_front();
                    s_action <= w.act;
                    s_coord_x <= w.x;
                    s_coord_y <= w.y;
                    s_coord_z <= w.z;
                    s_valid <= 1'b1;
                    drv_gap <= quiet ? 0 : $urandom_range(0, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : watch_results
        verdict_t v;
        int       g;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rcv_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display({"%0t ns: unexpected result, expected none, ",
                              "got kept=%0b in_box=%0b status=%0b"},
                             $time, m_kept, m_in_box, m_status);
                end else begin
                    v = verdict_q.pop_front();
                    check_bit("kept", v.kept, m_kept);
                    check_bit("in_box", v.in_box, m_in_box);
                    check_bit("status", v.status, m_status);
                end
            end
            if (rcv_wait > 0) begin
                m_ready <= 1'b0;
                rcv_wait <= rcv_wait - 1;
            end else if (hold_reqs != holds_done) begin
                m_ready <= 1'b0;
                rcv_wait <= LONG_HOLD;
                holds_done <= holds_done + 1;
            end else if (m_valid && m_ready) begin
                g = quiet ? 0 : $urandom_range(0, 19);
                if (g > 0) begin
                    m_ready <= 1'b0;
                    rcv_wait <= g - 1;
                end else begin
                    m_ready <= 1'b1;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic offer(logic [1:0] act, longint x, longint y, longint z);
        word_t w;
        w.act = act;
        w.x = fit(x);
        w.y = fit(y);
        w.z = fit(z);
        pending_q.push_back(w);
        n_pushed++;
        if (act != ACT_NONE) n_offered++;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_pushed || verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_radius(logic [RADIUS_W-1:0] r);
        wait_idle();
        @(posedge aclk);
        cfg_clash_radius <= r;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_now = r;
        n_settings++;
    endtask

    // a clear (most of the time), a cluster of atoms, then queries mostly aimed at the cluster
    task automatic run_cluster();
        int px [$], py [$], pz [$];
        int lo [3], hi [3], c [3], p [3];
        int n, spread, j, k, r;
        spread = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, 9000)
                                              : $urandom_range(8, 900);
        for (int a = 0; a < 3; a++) begin
            c[a] = jitter(100000);
            lo[a] = CMAX;
            hi[a] = CMIN;
        end
        if ($urandom_range(0, 4) != 0) offer(ACT_CLEAR, any_coord(), any_coord(), any_coord());
        n = $urandom_range(1, 16);
        repeat (n) begin
            for (int a = 0; a < 3; a++) begin
                p[a] = c[a] + jitter(spread);
                if (p[a] < lo[a]) lo[a] = p[a];
                if (p[a] > hi[a]) hi[a] = p[a];
            end
            px.push_back(p[0]);
            py.push_back(p[1]);
            pz.push_back(p[2]);
            offer(ACT_LOAD, p[0], p[1], p[2]);
        end
        repeat ($urandom_range(3, 8)) begin
            r = radius_now;
            j = $urandom_range(0, px.size() - 1);
            k = $urandom_range(0, 2);
            for (int a = 0; a < 3; a++) begin
                p[a] = (hi[a] - lo[a] >= 2) ?
                       lo[a] + 1 + int'($urandom_range(0, hi[a] - lo[a] - 2)) : lo[a];
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: offer(ACT_QUERY, px[j] + jitter(r + 2), py[j] + jitter(r + 2),
                                  pz[j] + jitter(r + 2));
                4: offer(ACT_QUERY, px[j], py[j], pz[j]);
                5, 6: offer(ACT_QUERY, p[0], p[1], p[2]);
                7: begin
                    p[k] = $urandom_range(0, 1) ? lo[k] : hi[k];
                    offer(ACT_QUERY, p[0], p[1], p[2]);
                end
                8: begin
                    p[k] = $urandom_range(0, 1) ? lo[k] - 1 : hi[k] + 1;
                    offer(ACT_QUERY, p[0], p[1], p[2]);
                end
                default: offer(2'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord());
            endcase
        end
        if ($urandom_range(0, 2) == 0) offer(ACT_NONE, any_coord(), any_coord(), any_coord());
    endtask

    initial begin
        int                  base;
        logic [RADIUS_W-1:0] r;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        set_radius(RADIUS_RESET);
        offer(ACT_QUERY, 5, -7, 9);
        offer(ACT_NONE, CMAX, CMIN, CMAX);
        offer(ACT_LOAD, CMIN, CMIN, CMIN);
        offer(ACT_LOAD, CMAX, CMAX, CMAX);
        offer(ACT_LOAD, 0, 0, 0);
        offer(ACT_QUERY, 0, 0, 0);
        offer(ACT_QUERY, 320, 0, 0);
        offer(ACT_QUERY, 321, 0, 0);
        offer(ACT_QUERY, CMIN, 0, 0);
        offer(ACT_QUERY, 0, CMAX, 0);
        offer(ACT_QUERY, 0, 0, CMIN);
        offer(ACT_QUERY, 5000, -5000, 5000);
        offer(ACT_CLEAR, CMAX, CMIN, -1);
        offer(ACT_QUERY, 0, 0, 0);
        offer(ACT_LOAD, 7, 7, 7);
        offer(ACT_QUERY, 7, 7, 7);

        set_radius('0);
        offer(ACT_CLEAR, 0, 0, 0);
        offer(ACT_LOAD, -10, -10, -10);
        offer(ACT_LOAD, 10, 10, 10);
        offer(ACT_LOAD, 3, -4, 5);
        offer(ACT_QUERY, 3, -4, 5);
        offer(ACT_QUERY, 3, -4, 6);

        set_radius({RADIUS_W{1'b1}});
        offer(ACT_CLEAR, 0, 0, 0);
        offer(ACT_LOAD, -20000, -20000, -20000);
        offer(ACT_LOAD, 20000, 20000, 20000);
        offer(ACT_LOAD, 0, 0, 0);
        offer(ACT_QUERY, 16383, 0, 0);
        offer(ACT_QUERY, 16384, 0, 0);

        // receiver backs off while words keep coming
        wait_idle();
        quiet = 1'b1;
        hold_reqs++;
        offer(ACT_CLEAR, 0, 0, 0);
        for (int i = 0; i < 8; i++) offer(ACT_LOAD, jitter(2000), jitter(2000), jitter(2000));
        for (int i = 0; i < 8; i++) offer(ACT_QUERY, jitter(1500), jitter(1500), jitter(1500));
        wait_idle();
        quiet = 1'b0;

        base = n_offered;
        while (n_offered - base < RAND_WORDS) begin
            case ($urandom_range(0, 5))
                0: r = '0;
                1: r = {RADIUS_W{1'b1}};
                2: r = RADIUS_RESET;
                default: r = $urandom_range(1, 3000);
            endcase
            set_radius(r);
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 3)) run_cluster();
        end

        wait_idle();
        repeat (32) @(posedge aclk);
        $display("Run covered %0d words under %0d clash radius settings, one long output stall.",
                 n_accepted, n_settings);
        $display("%0d queries fell inside the box, %0d clashed; %0d loads hit a full store.",
                 n_inbox, n_clash, n_dropped);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
design/acf_pkg.sv
design/acf_store.sv
design/acf_scan.sv
design/atom_clash_filter.sv
design/acf_checker.sv
tb/sv/tb_atom_clash_filter.sv
